// ===== hdl/brbs_pkg.sv =====
// Shared constants for the bell ring burst sequencer: register map, mode codes, reset values.
package brbs_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_A    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAP        = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_B    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_BURST      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_REST       = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_RING_COUNT = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE   = 3'd7;

  // Mode codes as seen on the result stream
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_RING  = 2'd1;
  localparam logic [1:0] MODE_AUDIO = 2'd2;

  // Register reset values
  localparam logic [31:0] RST_INTERVAL   = 32'd60000;
  localparam logic [7:0]  RST_PULSE_A    = 8'd2;
  localparam logic [7:0]  RST_GAP        = 8'd25;
  localparam logic [7:0]  RST_PULSE_B    = 8'd2;
  localparam logic [15:0] RST_BURST      = 16'd2000;
  localparam logic [15:0] RST_REST       = 16'd4000;
  localparam logic [3:0]  RST_RING_COUNT = 4'd3;
  localparam logic [7:0]  RST_DEBOUNCE   = 8'd10;

  // Saturation limits
  localparam logic [7:0]  PHASE_MAX  = 8'hFF;
  localparam logic [15:0] BURST_MAX  = 16'hFFFF;
  localparam logic [3:0]  BURSTS_MAX = 4'hF;

endpackage

// ===== hdl/bell_ring_burst_sequencer.sv =====
// Top level of the bell ring burst sequencer: tick register, sequencer state, result register.
//
// Usage:
//  - Input stream (in_t*): one transfer per 1 ms tick, carrying the hook switch level and
//    the audio-done flag. Every accepted tick yields exactly one result transfer.
//  - Result stream (out_t*): bell drive A/B levels, mode code and the audio play request
//    as they stand after that tick.
//  - Configuration: cfg_wr_en/cfg_addr/cfg_wdata write one of eight timing registers per
//    cycle; write only while no tick is in flight.
//  - From input transfer to result: the tick register loads at the input transfer, the
//    state update and result register load once the result register is free, and
//    out_tvalid is high from then on.
//  - Throughput is one tick per clock cycle while the receiver keeps up; the whole state update is a single pass of
//    counter increments and compares between the tick register and the result register.
//  - When the receiver stalls, the result register holds and the tick register can still
//    take one more transfer; after that in_tready drops until the result moves on.
//  - Reset (rst_n low, synchronous) empties both registers, loads the default timings and
//    returns the sequencer to idle with both drives low and the switch taken as on hook.
module bell_ring_burst_sequencer #(
  parameter int unsigned INTERVAL_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [0] switch_level, [1] audio_done
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // [0] bell_a, [1] bell_b,
                                                       // [3:2] mode_code, [4] play_request
  // configuration writes
  input  logic                             cfg_wr_en,
  input  logic [brbs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [brbs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  typedef enum logic [1:0] {
    TM_IDLE  = brbs_pkg::MODE_IDLE,
    TM_RING  = brbs_pkg::MODE_RING,
    TM_AUDIO = brbs_pkg::MODE_AUDIO
  } top_mode_t;

  typedef enum logic [1:0] {
    RP_IDLE,
    RP_RING,
    RP_REST
  } ring_phase_t;

  typedef enum logic [2:0] {
    PP_IDLE,
    PP_A,
    PP_GAP1,
    PP_B,
    PP_GAP2
  } pulse_phase_t;

  localparam logic [INTERVAL_BITS-1:0] IDLE_MAX = '1;
  localparam logic [INTERVAL_BITS-1:0] IDLE_ONE = {{(INTERVAL_BITS-1){1'b0}}, 1'b1};

  // configuration registers
  logic [31:0] interval_r;
  logic [7:0]  pulse_a_r, gap_r, pulse_b_r, debounce_r;
  logic [15:0] burst_r, rest_r;
  logic [3:0]  ring_count_r;

  // pipeline registers
  logic        in_valid_r;
  logic        sw_r, done_r;
  logic        out_valid_r;
  logic [7:0]  out_data_r;
  logic        advance;
  logic        step;

  // sequencer state
  top_mode_t              top_mode_r, top_mode_nxt;
  ring_phase_t            ring_phase_r, ring_phase_nxt;
  pulse_phase_t           pulse_phase_r, pulse_phase_nxt;
  logic [7:0]             phase_el_r, phase_el_nxt;
  logic [15:0]            burst_el_r, burst_el_nxt;
  logic [15:0]            rest_el_r, rest_el_nxt;
  logic [INTERVAL_BITS-1:0] idle_el_r, idle_el_nxt;
  logic [3:0]             bursts_r, bursts_nxt;
  logic                   sw_last_r, sw_last_nxt;
  logic [7:0]             sw_stable_r, sw_stable_nxt;
  logic                   drive_a_r, drive_a_nxt;
  logic                   drive_b_r, drive_b_nxt;
  logic                   lifted;
  logic [7:0]             out_data_nxt;

  // handshake: the result register frees up when empty or taken
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign step      = in_valid_r && advance;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r   <= brbs_pkg::RST_INTERVAL;
      pulse_a_r    <= brbs_pkg::RST_PULSE_A;
      gap_r        <= brbs_pkg::RST_GAP;
      pulse_b_r    <= brbs_pkg::RST_PULSE_B;
      burst_r      <= brbs_pkg::RST_BURST;
      rest_r       <= brbs_pkg::RST_REST;
      ring_count_r <= brbs_pkg::RST_RING_COUNT;
      debounce_r   <= brbs_pkg::RST_DEBOUNCE;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        brbs_pkg::CFG_INTERVAL:   interval_r   <= cfg_wdata;
        brbs_pkg::CFG_PULSE_A:    pulse_a_r    <= cfg_wdata[7:0];
        brbs_pkg::CFG_GAP:        gap_r        <= cfg_wdata[7:0];
        brbs_pkg::CFG_PULSE_B:    pulse_b_r    <= cfg_wdata[7:0];
        brbs_pkg::CFG_BURST:      burst_r      <= cfg_wdata[15:0];
        brbs_pkg::CFG_REST:       rest_r       <= cfg_wdata[15:0];
        brbs_pkg::CFG_RING_COUNT: ring_count_r <= cfg_wdata[3:0];
        brbs_pkg::CFG_DEBOUNCE:   debounce_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // next-state logic for one tick
  always_comb begin
    top_mode_nxt    = top_mode_r;
    ring_phase_nxt  = ring_phase_r;
    pulse_phase_nxt = pulse_phase_r;
    phase_el_nxt    = phase_el_r;
    burst_el_nxt    = burst_el_r;
    rest_el_nxt     = rest_el_r;
    idle_el_nxt     = idle_el_r;
    bursts_nxt      = bursts_r;
    sw_last_nxt     = sw_last_r;
    sw_stable_nxt   = sw_stable_r;
    drive_a_nxt     = drive_a_r;
    drive_b_nxt     = drive_b_r;
    lifted          = 1'b0;

    // debounce timer runs on every tick
    if (sw_stable_nxt != brbs_pkg::PHASE_MAX) sw_stable_nxt = sw_stable_nxt + 8'd1;

    case (top_mode_r)
      TM_IDLE: begin
        if (idle_el_nxt != IDLE_MAX) idle_el_nxt = idle_el_nxt + IDLE_ONE;
        if (32'(idle_el_nxt) >= interval_r && sw_r) begin
          top_mode_nxt    = TM_RING;
          bursts_nxt      = '0;
          ring_phase_nxt  = RP_RING;
          pulse_phase_nxt = PP_A;
          phase_el_nxt    = '0;
          burst_el_nxt    = '0;
          drive_a_nxt     = 1'b1;
          drive_b_nxt     = 1'b0;
        end
      end

      TM_RING: begin
        // switch sampling and lift detection
        if (sw_r != sw_last_r) sw_stable_nxt = '0;
        if (sw_stable_nxt > debounce_r && !sw_r) begin
          pulse_phase_nxt = PP_IDLE;
          drive_a_nxt     = 1'b0;
          drive_b_nxt     = 1'b0;
          if (bursts_nxt != brbs_pkg::BURSTS_MAX) bursts_nxt = bursts_nxt + 4'd1;
          rest_el_nxt     = '0;
          ring_phase_nxt  = RP_REST;
          top_mode_nxt    = TM_AUDIO;
          lifted          = 1'b1;
        end
        sw_last_nxt = sw_r;

        if (!lifted) begin
          case (ring_phase_r)
            RP_RING: begin
              if (burst_el_nxt != brbs_pkg::BURST_MAX) burst_el_nxt = burst_el_nxt + 16'd1;
              if (burst_el_nxt > burst_r) begin
                // burst over: quiet down and start the rest period
                pulse_phase_nxt = PP_IDLE;
                drive_a_nxt     = 1'b0;
                drive_b_nxt     = 1'b0;
                if (bursts_nxt != brbs_pkg::BURSTS_MAX) bursts_nxt = bursts_nxt + 4'd1;
                rest_el_nxt     = '0;
                ring_phase_nxt  = RP_REST;
                idle_el_nxt     = '0;
              end else begin
                // pulse pattern A, gap, B, gap
                if (phase_el_nxt != brbs_pkg::PHASE_MAX) phase_el_nxt = phase_el_nxt + 8'd1;
                case (pulse_phase_r)
                  PP_A: begin
                    if (phase_el_nxt >= pulse_a_r) begin
                      drive_a_nxt = 1'b0; pulse_phase_nxt = PP_GAP1; phase_el_nxt = '0;
                    end
                  end
                  PP_GAP1: begin
                    if (phase_el_nxt >= gap_r) begin
                      drive_b_nxt = 1'b1; pulse_phase_nxt = PP_B; phase_el_nxt = '0;
                    end
                  end
                  PP_B: begin
                    if (phase_el_nxt >= pulse_b_r) begin
                      drive_b_nxt = 1'b0; pulse_phase_nxt = PP_GAP2; phase_el_nxt = '0;
                    end
                  end
                  PP_GAP2: begin
                    if (phase_el_nxt >= gap_r) begin
                      drive_a_nxt = 1'b1; pulse_phase_nxt = PP_A; phase_el_nxt = '0;
                    end
                  end
                  default: ;
                endcase
              end
              // session complete
              if (bursts_nxt == ring_count_r) begin
                top_mode_nxt    = TM_IDLE;
                ring_phase_nxt  = RP_IDLE;
                pulse_phase_nxt = PP_IDLE;
                drive_a_nxt     = 1'b0;
                drive_b_nxt     = 1'b0;
              end
            end
            RP_REST: begin
              if (rest_el_nxt != brbs_pkg::BURST_MAX) rest_el_nxt = rest_el_nxt + 16'd1;
              if (rest_el_nxt >= rest_r) begin
                ring_phase_nxt  = RP_RING;
                pulse_phase_nxt = PP_A;
                phase_el_nxt    = '0;
                burst_el_nxt    = '0;
                drive_a_nxt     = 1'b1;
                drive_b_nxt     = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end

      TM_AUDIO: begin
        if (done_r) begin
          top_mode_nxt   = TM_IDLE;
          ring_phase_nxt = RP_IDLE;
          idle_el_nxt    = '0;
        end
      end

      default: ;
    endcase

    out_data_nxt = {3'b000, (top_mode_nxt == TM_AUDIO), top_mode_nxt, drive_b_nxt, drive_a_nxt};
  end

  // tick register, sequencer state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      top_mode_r    <= TM_IDLE;
      ring_phase_r  <= RP_IDLE;
      pulse_phase_r <= PP_IDLE;
      phase_el_r    <= '0;
      burst_el_r    <= '0;
      rest_el_r     <= '0;
      idle_el_r     <= '0;
      bursts_r      <= '0;
      sw_last_r     <= 1'b1;
      sw_stable_r   <= '0;
      drive_a_r     <= 1'b0;
      drive_b_r     <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) out_valid_r <= in_valid_r;
      if (step) begin
        top_mode_r    <= top_mode_nxt;
        ring_phase_r  <= ring_phase_nxt;
        pulse_phase_r <= pulse_phase_nxt;
        phase_el_r    <= phase_el_nxt;
        burst_el_r    <= burst_el_nxt;
        rest_el_r     <= rest_el_nxt;
        idle_el_r     <= idle_el_nxt;
        bursts_r      <= bursts_nxt;
        sw_last_r     <= sw_last_nxt;
        sw_stable_r   <= sw_stable_nxt;
        drive_a_r     <= drive_a_nxt;
        drive_b_r     <= drive_b_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sw_r   <= in_tdata[0];
      done_r <= in_tdata[1];
    end
    if (step) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/brbs_checker.sv =====
// Port-level checks for the bell ring burst sequencer, bound to the top level.
module brbs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // play request mirrors the audio mode code
  a_play_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4] == (out_tdata[3:2] == brbs_pkg::MODE_AUDIO)))
    else $error("play_request disagrees with mode_code");

  // unused mode code never shows
  a_mode_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:2] == brbs_pkg::MODE_IDLE ||
                    out_tdata[3:2] == brbs_pkg::MODE_RING ||
                    out_tdata[3:2] == brbs_pkg::MODE_AUDIO))
    else $error("mode_code out of range");

  // the two bell drives never overlap
  a_drives_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("bell drives A and B both high");

  // drives are quiet outside ringing
  a_quiet_outside_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[3:2] != brbs_pkg::MODE_RING) |-> (out_tdata[1:0] == 2'b00))
    else $error("bell drive active outside ringing");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

endmodule

bind bell_ring_burst_sequencer brbs_checker u_brbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
